### rtl/mexp_pkg.sv
`default_nettype none
package mexp_pkg;

    // Residues stay below the modulus (at most 2^62), so 63 bits hold every sum.
    localparam int VAL_W = 63;
    localparam int RES_W = 62;
    localparam int FIELD_W = 63;
    localparam int OPERAND_WIDTH_DEF = 63;

    localparam logic [VAL_W-1:0] MODULUS_RESET = 63'd1000000007;
    localparam logic [VAL_W-1:0] MODULUS_LIMIT = 63'h4000_0000_0000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } mexp_state_t;

    typedef struct packed {
        logic load;       // capture operands, set result to 1
        logic red_step;   // one bit of base mod m
        logic mm_start;   // load the shift-add product engine
        logic mm_square;  // operands for mm_start: sq*sq (else result*sq)
        logic mm_step;    // one shift-add step
        logic pow_write;  // result <= product
        logic sq_write;   // square <= product
        logic exp_shift;  // drop the exponent LSB
    } mexp_cmd_t;

    typedef struct packed {
        logic red_last;
        logic mm_done;
        logic exp_zero;
        logic exp_lsb;
        logic exp_last;
    } mexp_status_t;

endpackage
`default_nettype wire

### rtl/modular_exponentiation.sv
`default_nettype none
// Channel   | Direction | Handshake          | Payload
// s_        | in        | s_valid / s_ready  | s_base_value[62:0], s_exponent[62:0]
// m_        | out       | m_valid / m_ready  | m_power_result[61:0]
// APB       | in        | psel, penable      | paddr[3:0], pwdata/prdata[63:0], modulus at 0x0
//
// Per item: an accept, a bit-serial reduction of the base mod m (W = OPERAND_WIDTH bits),
// then per exponent bit up to the top set one a decision state, a multiply when the bit
// is set and a squaring except after the top bit, then a result state held through any
// m_ready stall. Products come from the one-bit-per-cycle shift-add product engine.
// One item in flight; s_ready is high only while idle; m_power_result holds until m_ready.
// Synchronous active-low reset idles the controller and sets the modulus to 1000000007.
module modular_exponentiation import mexp_pkg::*; #(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  wire                aclk,
    input  wire                aresetn,
    // input items
    input  wire                s_valid,
    output logic               s_ready,
    input  wire  [FIELD_W-1:0] s_base_value,
    input  wire  [FIELD_W-1:0] s_exponent,
    // result items
    output logic               m_valid,
    input  wire                m_ready,
    output logic [RES_W-1:0]   m_power_result,
    // configuration
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire  [3:0]         paddr,
    input  wire  [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    logic [VAL_W-1:0] modulus_reg;
    logic [VAL_W-1:0] modulus_next;
    logic             cfg_wr;

    mexp_cmd_t    cmd;
    mexp_status_t status;

    // Only the modulus lives here; 8-byte stride, paddr[3] selects the register slot.
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr[3] == 1'b0);

    always_comb begin
        modulus_next = modulus_reg;
        if (cfg_wr) modulus_next = pwdata[VAL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= MODULUS_RESET;
        end else begin
            modulus_reg <= modulus_next;
        end
    end

    assign prdata = paddr[3] ? 64'd0 : {1'b0, modulus_reg};

    // Sequencer: reduce base, then walk exponent bits LSB first.
    mexp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Residue registers, doubling unit and add/reduce unit.
    mexp_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .base_value   (s_base_value),
        .exponent     (s_exponent),
        .modulus      (modulus_reg),
        .cmd          (cmd),
        .status       (status),
        .power_result (m_power_result)
    );

endmodule
`default_nettype wire

### rtl/mexp_ctrl.sv
`default_nettype none
module mexp_ctrl import mexp_pkg::*; (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_valid,
    output logic         s_ready,
    output logic         m_valid,
    input  wire          m_ready,
    input  mexp_status_t status,
    output mexp_cmd_t    cmd
);

    mexp_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_REDUCE;
            end
            ST_REDUCE: begin
                if (status.red_last) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (status.exp_zero) state_next = ST_DONE;
                else if (status.exp_lsb) state_next = ST_MUL;
                else state_next = ST_SQR;
            end
            ST_MUL: begin
                if (status.mm_done) begin
                    state_next = status.exp_last ? ST_DONE : ST_SQR;
                end
            end
            ST_SQR: begin
                if (status.mm_done) state_next = ST_CHECK;
            end
            ST_DONE: begin
                if (m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_REDUCE: begin
                cmd.red_step = 1'b1;
            end
            ST_CHECK: begin
                if (!status.exp_zero) begin
                    cmd.mm_start  = 1'b1;
                    cmd.mm_square = !status.exp_lsb;
                end
            end
            ST_MUL: begin
                if (status.mm_done) begin
                    cmd.pow_write = 1'b1;
                    if (status.exp_last) begin
                        cmd.exp_shift = 1'b1;
                    end else begin
                        cmd.mm_start  = 1'b1;
                        cmd.mm_square = 1'b1;
                    end
                end else begin
                    cmd.mm_step = 1'b1;
                end
            end
            ST_SQR: begin
                if (status.mm_done) begin
                    cmd.sq_write  = 1'b1;
                    cmd.exp_shift = 1'b1;
                end else begin
                    cmd.mm_step = 1'b1;
                end
            end
            ST_DONE: begin
                m_valid = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/mexp_dp.sv
`default_nettype none
module mexp_dp import mexp_pkg::*; #(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  wire                aclk,
    input  wire  [FIELD_W-1:0] base_value,
    input  wire  [FIELD_W-1:0] exponent,
    input  wire  [VAL_W-1:0]   modulus,
    input  mexp_cmd_t          cmd,
    output mexp_status_t       status,
    output logic [RES_W-1:0]   power_result
);

    localparam int CNT_W = $clog2(OPERAND_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OPERAND_WIDTH - 1);

    logic [VAL_W-1:0]         m_reg;
    logic [VAL_W-1:0]         pow_reg;
    logic [VAL_W-1:0]         sq_reg;
    logic [VAL_W-1:0]         acc_reg;
    logic [VAL_W-1:0]         dbl_reg;
    logic [VAL_W-1:0]         y_reg;
    logic [OPERAND_WIDTH-1:0] exp_reg;
    logic [OPERAND_WIDTH-1:0] base_reg;
    logic [CNT_W-1:0]         cnt_reg;

    logic [VAL_W-1:0] m_eff;
    logic             bit_in;
    logic [VAL_W-1:0] dbl_sh;
    logic [VAL_W-1:0] dbl_red;
    logic [VAL_W-1:0] sum;
    logic [VAL_W-1:0] sum_red;
    logic [VAL_W-1:0] pow_op;

    // zero modulus acts as 1, anything above 2^62 saturates
    always_comb begin
        if (modulus == '0) m_eff = VAL_W'(1);
        else if (modulus > MODULUS_LIMIT) m_eff = MODULUS_LIMIT;
        else m_eff = modulus;
    end

    // doubling unit; during base reduction it shifts in base bits MSB first
    assign bit_in  = cmd.red_step & base_reg[OPERAND_WIDTH-1];
    assign dbl_sh  = {dbl_reg[VAL_W-2:0], bit_in};
    assign dbl_red = (dbl_sh >= m_reg) ? dbl_sh - m_reg : dbl_sh;

    assign sum     = acc_reg + dbl_reg;
    assign sum_red = (sum >= m_reg) ? sum - m_reg : sum;

    // result starts at 1, which is 0 mod 1
    assign pow_op  = (pow_reg >= m_reg) ? '0 : pow_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_reg    <= m_eff;
            pow_reg  <= VAL_W'(1);
            exp_reg  <= exponent[OPERAND_WIDTH-1:0];
            base_reg <= base_value[OPERAND_WIDTH-1:0];
            dbl_reg  <= '0;
            cnt_reg  <= '0;
        end
        if (cmd.red_step) begin
            dbl_reg  <= dbl_red;
            base_reg <= {base_reg[OPERAND_WIDTH-2:0], 1'b0};
            cnt_reg  <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_LAST) sq_reg <= dbl_red;
        end
        if (cmd.mm_step) begin
            if (y_reg[0]) acc_reg <= sum_red;
            dbl_reg <= dbl_red;
            y_reg   <= {1'b0, y_reg[VAL_W-1:1]};
        end
        if (cmd.pow_write) pow_reg <= acc_reg;
        if (cmd.sq_write) sq_reg <= acc_reg;
        if (cmd.exp_shift) exp_reg <= {1'b0, exp_reg[OPERAND_WIDTH-1:1]};
        if (cmd.mm_start) begin
            acc_reg <= '0;
            y_reg   <= sq_reg;
            if (cmd.mm_square) dbl_reg <= sq_reg;
            else dbl_reg <= pow_op;
        end
    end

    assign status.red_last = (cnt_reg == CNT_LAST);
    assign status.mm_done  = (y_reg == '0);
    assign status.exp_zero = (exp_reg == '0);
    assign status.exp_lsb  = exp_reg[0];
    assign status.exp_last = (exp_reg[OPERAND_WIDTH-1:1] == '0);

    assign power_result = pow_reg[RES_W-1:0];

endmodule
`default_nettype wire

### bench/modular_exponentiation_tb.sv
`default_nettype none
module modular_exponentiation_tb import mexp_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // Register map: the modulus is wider than 32 bits, so registers sit on 8-byte strides.
    localparam logic [3:0] MODULUS_ADDR = 4'h0;

    // Worst item: a full-width base reduction plus 63 exponent bits, each with a full multiply
    // and a full square, plus short stalls on both sides.
    // The watchdog allows several times that with no handshake at all.
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_TAIL     = 64;

    typedef struct {
        logic [FIELD_W-1:0] base_value;
        logic [FIELD_W-1:0] exponent;
        logic [RES_W-1:0]   power_result;
    } power_item_t;

    logic               aclk;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [FIELD_W-1:0] s_base_value   = '0;
    logic [FIELD_W-1:0] s_exponent     = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [RES_W-1:0]   m_power_result;
    logic               psel           = 1'b0;
    logic               penable        = 1'b0;
    logic               pwrite         = 1'b0;
    logic [3:0]         paddr          = '0;
    logic [63:0]        pwdata         = '0;
    logic [63:0]        prdata;
    logic               pready;

    // Shadow of the modulus register as the bench believes it to be.
    logic [VAL_W-1:0]   modulus_shadow = MODULUS_RESET;

    power_item_t        pending_powers[$];
    int                 fail_count     = 0;
    int                 idle_cycles    = 0;
    int                 stall_left     = 0;
    bit                 idle_en        = 1'b1;

    modular_exponentiation u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_base_value   (s_base_value),
        .s_exponent     (s_exponent),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_power_result (m_power_result),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Power predictor. Square-and-multiply with full-width products; a
    // zero modulus acts as 1 and anything above 2^62 clamps to 2^62.
    // ------------------------------------------------------------------
    function automatic logic [RES_W-1:0] predict_power(input logic [FIELD_W-1:0] base,
                                                       input logic [FIELD_W-1:0] expo,
                                                       input logic [VAL_W-1:0]   mod_reg);
        logic [VAL_W-1:0]   m;
        logic [VAL_W-1:0]   sq;
        logic [VAL_W-1:0]   acc;
        logic [FIELD_W-1:0] e;
        logic [2*VAL_W-1:0] prod;
        if (mod_reg == '0)
            m = 1;
        else if (mod_reg > MODULUS_LIMIT)
            m = MODULUS_LIMIT;
        else
            m = mod_reg;
        sq  = base % m;
        e   = expo;
        // zero exponent returns 1 unreduced, even for modulus 1
        acc = 1;
        while (e != '0) begin
            if (e[0]) begin
                prod = acc * sq;
                prod = prod % m;
                acc  = prod[VAL_W-1:0];
            end
            prod = sq * sq;
            prod = prod % m;
            sq   = prod[VAL_W-1:0];
            e    = e >> 1;
        end
        return acc[RES_W-1:0];
    endfunction

    function automatic logic [62:0] rand63();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[62:0];
    endfunction

    // Base: mostly full-width random, with zero, all-ones and small values mixed in.
    function automatic logic [FIELD_W-1:0] random_base();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return '0;
        else if (pick == 1)
            return '1;
        else if (pick == 2)
            return FIELD_W'($urandom_range(1, 1000));
        return rand63();
    endfunction

    // Exponent: short ones dominate to keep run time down; a few full-width
    // ones make every exponent bit toggle.
    function automatic logic [FIELD_W-1:0] random_exponent();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick < 2)
            return rand63();
        else if (pick == 2)
            return FIELD_W'($urandom_range(0, 1));
        return rand63() >> (FIELD_W - $urandom_range(1, 16));
    endfunction

    // ------------------------------------------------------------------
    // Input side: one item per call. Valid is left high after the accept
    // so a following call can present the next item with no bubble.
    // ------------------------------------------------------------------
    task automatic send_item(input logic [FIELD_W-1:0] base, input logic [FIELD_W-1:0] expo);
        power_item_t item;
        if (idle_en && $urandom_range(0, 2) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_base_value <= base;
        s_exponent   <= expo;
        do @(posedge aclk); while (!s_ready);
        item.base_value   = base;
        item.exponent     = expo;
        item.power_result = predict_power(base, expo, modulus_shadow);
        pending_powers.push_back(item);
    endtask

    // Drop valid and let every outstanding result come back.
    task automatic wait_all_results();
        s_valid <= 1'b0;
        while (pending_powers.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // APB access. Each transfer ends with the bus idle so that two
    // transfers never drive psel twice in the same step.
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apb_read_check(input logic [3:0] addr, input logic [63:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== want) begin
            $display("%0t: readback addr 0x%0h mismatch expected 0x%0h actual 0x%0h",
                     $time, addr, want, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // Only called with nothing in flight. Bits above 62 are dropped by the register.
    task automatic set_modulus(input logic [63:0] value);
        apb_write(MODULUS_ADDR, value);
        modulus_shadow = value[VAL_W-1:0];
        apb_read_check(MODULUS_ADDR, {1'b0, modulus_shadow});
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure bursts while idling is enabled,
    // always ready otherwise.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 3) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end else begin
            m_ready    <= 1'b1;
        end
    end

    // Scoreboard: each accepted result against the oldest prediction, plus
    // the handshake-activity counter for the watchdog.
    always @(posedge aclk) begin
        power_item_t want;
        if (!aresetn) begin
            idle_cycles <= 0;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_valid && m_ready) begin
                if (pending_powers.size() == 0) begin
                    $display("%0t: unexpected result power_result %0d", $time, m_power_result);
                    fail_count++;
                end else begin
                    want = pending_powers.pop_front();
                    if (m_power_result !== want.power_result) begin
                        $display("%0t: power_result mismatch (base %0d exp %0d) expected %0d actual %0d",
                                 $time, want.base_value, want.exponent,
                                 want.power_result, m_power_result);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("%0t: watchdog, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset value of the modulus, trivial exponents and boundary bases.
    task automatic test_reset_modulus();
        apb_read_check(MODULUS_ADDR, {1'b0, MODULUS_RESET});
        send_item('0, '0);
        send_item('0, 63'd5);
        send_item(63'd2, 63'd10);
        send_item('1, '1);
        send_item(63'd1000000007, 63'd1);
        send_item(63'd1000000006, 63'd2);
        send_item(63'd123456789, '0);
        wait_all_results();
    endtask

    // Modulus corners: 1, zero (acts as 1), the 2^62 limit, values above it
    // (clamped), and the smallest nontrivial modulus.
    task automatic test_modulus_extremes();
        set_modulus(64'd1);
        send_item('1, '0);
        send_item(63'd5, 63'd3);
        wait_all_results();

        set_modulus(64'd0);
        send_item('0, '0);
        send_item(63'd7, 63'd1);
        wait_all_results();

        set_modulus({1'b0, MODULUS_LIMIT});
        send_item('1, '1);
        send_item(MODULUS_LIMIT - 63'd1, 63'd2);
        send_item(63'd3, 63'd61);
        wait_all_results();

        // top pwdata bit set as well; the register keeps 63 bits
        set_modulus(64'hFFFF_FFFF_FFFF_FFFF);
        send_item('1, 63'd5);
        send_item(MODULUS_LIMIT + 63'd5, 63'd1);
        wait_all_results();

        set_modulus({1'b0, MODULUS_LIMIT + 63'd1});
        send_item(63'd2, 63'd62);
        wait_all_results();

        set_modulus(64'd2);
        send_item(63'd3, '1);
        wait_all_results();
    endtask

    // Random items across several moduli, with idling on both sides. In one
    // phase the sender holds off mid-stream until everything has drained.
    task automatic test_random_phases();
        logic [63:0] m;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    m = {1'b0, rand63() >> (FIELD_W - $urandom_range(20, 40))};
                end
                1: begin
                    m = {1'b0, MODULUS_LIMIT};
                end
                2: begin
                    m = {1'b0, rand63() >> 1};
                end
                3: begin
                    m = 64'($urandom_range(2, 255));
                end
                4: begin
                    m = {$urandom_range(0, 1) == 1, rand63() | MODULUS_LIMIT};
                end
                default: begin
                    m = {1'b0, rand63() >> (FIELD_W - $urandom_range(1, 63))};
                end
            endcase
            set_modulus(m);
            for (int i = 0; i < 12; i++) begin
                if (phase == 2 && i == 6)
                    wait_all_results();
                send_item(random_base(), random_exponent());
            end
            wait_all_results();
        end
    endtask

    // Closing stretch: no idling anywhere, items offered back to back.
    task automatic test_back_to_back();
        idle_en = 1'b0;
        set_modulus({1'b0, rand63() >> (FIELD_W - $urandom_range(8, 62))});
        for (int i = 0; i < 15; i++)
            send_item(random_base(), random_exponent());
        wait_all_results();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_modulus();
        test_modulus_extremes();
        test_random_phases();
        test_back_to_back();

        wait_all_results();
        repeat (DRAIN_TAIL) @(posedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
